// ===== hw/rtl/atab_pkg.sv =====
// ----------------------------------------------------------------------------
// atab_pkg: shared types and constants
// Field widths, default batch size and the job record for the batcher.
// ----------------------------------------------------------------------------
package atab_pkg;
	localparam int TimeW = 32;
	localparam int AngleW = 24;
	localparam int RateW = 32;
	localparam int AccelW = 31;
	localparam int DefaultBatchSize = 5;
	localparam int DivNumW = 46;
	localparam logic [9:0] Scale = 10'd1000;

	typedef struct packed {
		logic              is_accel;
		logic [TimeW-1:0]  sample_time;
		logic [TimeW-1:0]  gap;
		logic signed [RateW:0] diff;
	} job_t;
endpackage

// ===== hw/rtl/atab_front.sv =====
// ----------------------------------------------------------------------------
// atab_front: sample classification
// Tracks history, forms the gap and angle difference, and queues a velocity
// job for each sample that needs one.
// ----------------------------------------------------------------------------
module atab_front import atab_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [TimeW-1:0]         in_time,
	input  logic signed [AngleW-1:0] in_angle,
	output logic                     job_valid,
	output job_t                     job,
	input  logic                     done
);
	logic [1:0] stage_q;
	logic busy_q;
	logic signed [AngleW-1:0] prev_angle_q;
	logic [TimeW-1:0] prev_time_q;
	logic [TimeW-1:0] gap;
	logic take;

	assign gap = in_time - prev_time_q;
	assign in_ready = !busy_q;
	assign take = in_valid && in_ready;
	assign job_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= 2'd0;
			busy_q <= 1'b0;
		end else begin
			if (take && stage_q != 2'd0 && gap != '0) begin
				busy_q <= 1'b1;
				if (stage_q == 2'd1) stage_q <= 2'd2;
			end else if (take && stage_q == 2'd0) begin
				stage_q <= 2'd1;
			end
			if (busy_q && done) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && (stage_q == 2'd0 || gap != '0)) begin
			prev_angle_q <= in_angle;
			prev_time_q <= in_time;
		end
		if (take) begin
			job.is_accel <= (stage_q == 2'd2);
			job.sample_time <= in_time;
			job.gap <= gap;
			job.diff <= (RateW+1)'(in_angle) - (RateW+1)'(prev_angle_q);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> !in_ready)
		else $error("front accepted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && stage_q == 2'd0) |=> !busy_q) else $error("first sample made a job");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> stage_q != 2'd0) else $error("job without history");
endmodule

// ===== hw/rtl/atab_div.sv =====
// ----------------------------------------------------------------------------
// atab_div: iterative scaled divider
// Computes sat32(trunc(num * 1000 / gap)) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atab_div import atab_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [RateW:0]  num,
	input  logic [TimeW-1:0]       den,
	output logic                   busy,
	output logic                   fin,
	output logic signed [RateW-1:0] quo
);
	logic [DivNumW-1:0] q_q;
	logic [TimeW:0] r_q;
	logic [TimeW-1:0] d_q;
	logic neg_q, run_q, fin_q;
	logic [5:0] cnt_q;
	logic [RateW:0] mag;
	logic [DivNumW-1:0] prod;
	logic [TimeW:0] rs, rt;
	logic [DivNumW-1:0] m;

	assign mag = num[RateW] ? -num : num;
	assign prod = DivNumW'(mag) * DivNumW'(Scale);
	assign rs = {r_q[TimeW-1:0], q_q[DivNumW-1]};
	assign rt = rs - {1'b0, d_q};
	assign busy = run_q;
	assign fin = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(DivNumW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= prod;
			r_q <= '0;
			d_q <= den;
			neg_q <= num[RateW];
		end else if (run_q) begin
			if (!rt[TimeW]) begin
				r_q <= rt;
				q_q <= {q_q[DivNumW-2:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[DivNumW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		m = q_q;
		if (!neg_q) quo = (m > DivNumW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : RateW'(m);
		else if (m >= DivNumW'(33'h0_8000_0000)) quo = 32'sh8000_0000;
		else quo = -RateW'(m);
	end

	assert property (@(posedge clk) disable iff (!arst_n) fin |-> !busy)
		else $error("finish while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy)
		else $error("start ignored");
	assert property (@(posedge clk) disable iff (!arst_n) fin |-> $past(busy))
		else $error("spurious finish");
endmodule

// ===== hw/rtl/atab_back.sv =====
// ----------------------------------------------------------------------------
// atab_back: rate computation and batching
// Runs the velocity and acceleration divisions, stores kept points and
// streams out a full batch.
// ----------------------------------------------------------------------------
module atab_back import atab_pkg::*; #(
	parameter int BatchSize = DefaultBatchSize
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  job_t              job,
	output logic              done,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TimeW-1:0]  out_time,
	output logic [AccelW-1:0] out_accel,
	output logic              out_last
);
	localparam int IdxW = (BatchSize > 1) ? $clog2(BatchSize) : 1;
	localparam int FillW = $clog2(BatchSize + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001, ST_VEL = 5'b00010, ST_ACC = 5'b00100,
		ST_EMIT = 5'b01000, ST_DONE = 5'b10000
	} state_t;

	state_t st_q;
	logic signed [RateW-1:0] prev_vel_q, vel_q;
	logic [FillW-1:0] fill_q;
	logic [IdxW-1:0] rd_q;
	logic start, dbusy, dfin;
	logic signed [RateW:0] num;
	logic signed [RateW-1:0] quo;
	logic [TimeW-1:0] tstore_q [BatchSize];
	logic [AccelW-1:0] astore_q [BatchSize];

	assign start = (st_q == ST_IDLE && job_valid) || (st_q == ST_VEL && dfin && job.is_accel);
	assign num = (st_q == ST_IDLE) ? job.diff :
		(RateW+1)'(quo) - (RateW+1)'(prev_vel_q);

	atab_div u_div (.clk, .arst_n, .start, .num, .den(job.gap),
		.busy(dbusy), .fin(dfin), .quo);

	assign done = (st_q == ST_DONE);
	assign out_valid = (st_q == ST_EMIT);
	assign out_time = tstore_q[rd_q];
	assign out_accel = astore_q[rd_q];
	assign out_last = (32'(rd_q) == BatchSize - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			prev_vel_q <= '0;
			vel_q <= '0;
			fill_q <= '0;
			rd_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (job_valid) st_q <= ST_VEL;
				ST_VEL: if (dfin) begin
					if (job.is_accel) begin
						vel_q <= quo;
						st_q <= ST_ACC;
					end else begin
						prev_vel_q <= quo;
						st_q <= ST_DONE;
					end
				end
				ST_ACC: if (dfin) begin
					prev_vel_q <= vel_q;
					if (!quo[RateW-1]) begin
						if (32'(fill_q) == BatchSize - 1) begin
							fill_q <= '0;
							rd_q <= '0;
							st_q <= ST_EMIT;
						end else begin
							fill_q <= fill_q + 1'b1;
							st_q <= ST_DONE;
						end
					end else st_q <= ST_DONE;
				end
				ST_EMIT: if (out_ready) begin
					if (out_last) st_q <= ST_DONE;
					else rd_q <= rd_q + 1'b1;
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_ACC && dfin && !quo[RateW-1]) begin
			tstore_q[IdxW'(fill_q)] <= job.sample_time;
			astore_q[IdxW'(fill_q)] <= quo[AccelW-1:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !dbusy)
		else $error("emit during division");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(rd_q)) else $error("emit moved");
	assert property (@(posedge clk) disable iff (!arst_n) 32'(fill_q) < BatchSize)
		else $error("fill overrun");
endmodule

// ===== hw/rtl/angle_to_acceleration_batcher.sv =====
// ----------------------------------------------------------------------------
// angle_to_acceleration_batcher: acceleration estimator with batching
// Estimates acceleration from timestamped angles and emits batches of points.
// ----------------------------------------------------------------------------
// Usage: samples enter on the s_axis group; tdata holds the time in the low
// 32 bits and the signed angle above it. Points leave on the m_axis group,
// tdata holding the time, then the 31-bit acceleration; tlast marks the
// final point of each batch. One sample is taken at a time. A first sample
// or one with a zero time gap makes no division job. A second sample runs
// one division of 46 steps, plus the hand-over, before the next one can be
// taken. A later one takes two divisions in turn on the one bit-serial
// divider. A full batch then adds BatchSize transfers at the pace of the
// receiver; a stalled receiver holds the block and the front queue slot
// until the batch has gone. Reset clears the history and the batch fill;
// stored points need no clearing.
// ----------------------------------------------------------------------------
module angle_to_acceleration_batcher import atab_pkg::*; #(
	parameter int BatchSize = DefaultBatchSize
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // sample_time_ms[31:0], angle[55:32], zeros
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // point_time_ms[31:0], acceleration[62:32], zero
	output logic        m_axis_tlast
);
	logic job_valid, done;
	job_t job;
	logic [TimeW-1:0] out_time;
	logic [AccelW-1:0] out_accel;

	atab_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_time(s_axis_tdata[31:0]), .in_angle(s_axis_tdata[55:32]),
		.job_valid, .job, .done);

	atab_back #(.BatchSize(BatchSize)) u_back (.clk, .arst_n, .job_valid, .job, .done,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_time, .out_accel,
		.out_last(m_axis_tlast));

	assign m_axis_tdata = {1'b0, out_accel, out_time};
endmodule
